// File: rtl/core/ffr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the fixed frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

  // Byte and field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CfgIndexW = 8;

  // Default number of payload bytes per frame (1..8)
  localparam int unsigned PayloadBytesDef = 8;

  // Register reset values
  localparam logic [ByteW-1:0] SyncByteRst = 8'hEF;
  localparam logic [ByteW-1:0] EndByteRst  = 8'hFE;
  localparam logic [ByteW-1:0] TypeLowRst  = 8'h51;
  localparam logic [ByteW-1:0] TypeHighRst = 8'h53;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CfgSyncByte = 8'd0,
    CfgEndByte  = 8'd1,
    CfgTypeLow  = 8'd2,
    CfgTypeHigh = 8'd3
  } cfg_index_e;

  // Current register set
  typedef struct packed {
    logic [ByteW-1:0] sync_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] type_low;
    logic [ByteW-1:0] type_high;
  } cfg_t;

  // Assembler status seen by the top level
  typedef struct packed {
    logic [PosW-1:0] pos;      // next byte position, 0 = hunting for sync
    logic            in_vld;   // input register holds a byte
    logic            fire;     // input byte processed this cycle
  } asm_status_t;

endpackage

// File: rtl/core/ffr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_cfg_regs
// Configuration register file: sync byte, end byte and type range.
// ----------------------------------------------------------------------------
module ffr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ffr_pkg::ByteW-1:0]     cfg_data_i,
  output ffr_pkg::cfg_t                 cfg_o
);

  ffr_pkg::cfg_t cfg_d, cfg_q;

  // Writes never stall
  assign cfg_ready_o = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ffr_pkg::CfgSyncByte: cfg_d.sync_byte = cfg_data_i;
        ffr_pkg::CfgEndByte:  cfg_d.end_byte  = cfg_data_i;
        ffr_pkg::CfgTypeLow:  cfg_d.type_low  = cfg_data_i;
        ffr_pkg::CfgTypeHigh: cfg_d.type_high = cfg_data_i;
        default:              cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte <= ffr_pkg::SyncByteRst;
      cfg_q.end_byte  <= ffr_pkg::EndByteRst;
      cfg_q.type_low  <= ffr_pkg::TypeLowRst;
      cfg_q.type_high <= ffr_pkg::TypeHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ffr_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_assembler
// Input byte register, frame position tracking, byte store, frame check and
// result register.
// ----------------------------------------------------------------------------
module ffr_assembler #(
  parameter int unsigned PayloadBytes = ffr_pkg::PayloadBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffr_pkg::cfg_t                cfg_i,
  // byte input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ffr_pkg::ByteW-1:0]    in_byte_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_ok_o,
  output logic [ffr_pkg::ByteW-1:0]    out_type_o,
  output logic [ffr_pkg::PayloadW-1:0] out_payload_o,
  output ffr_pkg::asm_status_t         status_o
);

  localparam int unsigned StoreDepth = 1 + PayloadBytes;
  localparam logic [ffr_pkg::PosW-1:0] EndPos = ffr_pkg::PosW'(2 + PayloadBytes);

  // Input register
  logic                      in_vld_d, in_vld_q;
  logic [ffr_pkg::ByteW-1:0] in_byte_q;
  logic                      fire;

  // Frame state
  logic [ffr_pkg::PosW-1:0]  pos_d, pos_q;
  logic [ffr_pkg::ByteW-1:0] store_q [StoreDepth];

  // Result register
  logic                         out_vld_d, out_vld_q;
  logic                         out_ok_q;
  logic [ffr_pkg::ByteW-1:0]    out_type_q;
  logic [ffr_pkg::PayloadW-1:0] out_pay_q;

  logic                         is_sync, is_store, is_done;
  logic                         frame_ok;
  logic [ffr_pkg::PayloadW-1:0] payload;

  // Process the held byte when the result register can take a result
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Byte classification; sync wins over every position
  assign is_sync  = (in_byte_q == cfg_i.sync_byte);
  assign is_store = !is_sync && (pos_q != '0) && (pos_q < EndPos);
  assign is_done  = !is_sync && (pos_q == EndPos);

  // Position update
  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      priority if (is_sync) begin
        pos_d = ffr_pkg::PosW'(1);
      end else if (is_store) begin
        pos_d = pos_q + ffr_pkg::PosW'(1);
      end else if (is_done) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Frame store: entry i holds the byte of position i + 1
  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < StoreDepth; i++) begin
      if (fire && is_store && (pos_q == ffr_pkg::PosW'(i + 1))) begin
        store_q[i] <= in_byte_q;
      end
    end
  end

  // Payload, first byte highest, right aligned
  always_comb begin
    payload = '0;
    for (int unsigned i = 1; i < StoreDepth; i++) begin
      payload[(StoreDepth - 1 - i) * ffr_pkg::ByteW +: ffr_pkg::ByteW] = store_q[i];
    end
  end

  assign frame_ok = (in_byte_q == cfg_i.end_byte) &&
                    (store_q[0] >= cfg_i.type_low) &&
                    (store_q[0] <= cfg_i.type_high);

  // Result register
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (fire && is_done) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_done) begin
      out_ok_q   <= frame_ok;
      out_type_q <= store_q[0];
      out_pay_q  <= payload;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_ok_o      = out_ok_q;
  assign out_type_o    = out_type_q;
  assign out_payload_o = out_pay_q;

  assign status_o.pos    = pos_q;
  assign status_o.in_vld = in_vld_q;
  assign status_o.fire   = fire;

endmodule

// File: rtl/core/fixed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_receiver
// Deframer for fixed-length serial frames: sync, type, payload, end byte.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel, one per transaction. While hunting,
//   bytes other than the sync byte are dropped; a sync byte at any position
//   restarts the frame. On the end position one result leaves on m_axis:
//   type and payload in tdata, the ok flag in tuser. Rejected frames still
//   give a result with the flag low.
//   Throughput is one byte per cycle while m_axis does not stall. A byte is
//   accepted into the input register and checked from there; the frame
//   result passes through the result register, which drives m_axis_tvalid.
//   If m_axis stalls with a result pending, the next byte waits in the
//   input register and s_axis_tready drops while it is held.
//   The cfg channel writes sync byte, end byte, type low, type high at
//   indexes 0..3; other indexes are ignored; it never stalls. Write only
//   while no frame is in flight.
//   Reset clears the frame position and both valids and loads the default
//   register values; the byte store needs no clearing.
// ----------------------------------------------------------------------------
module fixed_frame_receiver #(
  parameter int unsigned PayloadBytes = ffr_pkg::PayloadBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // byte input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  // frame result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata,   // [7:0] frame_type, [71:8] payload
  output logic [0:0]                    m_axis_tuser    // [0] frame_ok
);

  localparam logic [ffr_pkg::PosW-1:0] EndPos = ffr_pkg::PosW'(2 + PayloadBytes);

  ffr_pkg::cfg_t                cfg;
  ffr_pkg::asm_status_t         status;
  logic                         res_ok;
  logic [ffr_pkg::ByteW-1:0]    res_type;
  logic [ffr_pkg::PayloadW-1:0] res_payload;

  ffr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ffr_assembler #(
    .PayloadBytes (PayloadBytes)
  ) u_asm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_ok_o      (res_ok),
    .out_type_o    (res_type),
    .out_payload_o (res_payload),
    .status_o      (status)
  );

  assign m_axis_tdata = {res_payload, res_type};
  assign m_axis_tuser = res_ok;

`ifndef SYNTH
  // Position never runs past the end byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pos <= EndPos)
    else $error("frame position beyond end position");

  // A new result only follows a processed byte at the end position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(status.fire) && ($past(status.pos) == EndPos))
    else $error("result without completed frame");

  // Input stalls only when a byte is held behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> status.in_vld && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back pressure");

  // Position returns to hunting after a completed frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> status.pos == '0 || status.pos == ffr_pkg::PosW'(1))
    else $error("position not reset after frame");
`endif

endmodule

// File: bench/tb_fixed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_frame_receiver
// Self-checking bench for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
// A byte stream of good frames, rejected frames, frames cut short by a new
// sync byte and line noise is fed in through the s_axis channel. A local
// model of the deframer predicts every frame result at the moment its byte
// is accepted; results leaving on m_axis are compared field by field in
// arrival order. The run walks through several register settings (reset
// values, full-range extremes, end byte equal to sync, empty type window,
// random windows), with random valid/ready bursts, one long output stall
// that backs up the input, and drain points between settings.
// ----------------------------------------------------------------------------
module tb_fixed_frame_receiver;

  localparam int unsigned PayloadBytes  = ffr_pkg::PayloadBytesDef;
  localparam int unsigned StoreDepth    = 1 + PayloadBytes;
  localparam int unsigned EndPos        = 2 + PayloadBytes;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted    = 20;

  // Register indexes outside the defined map; writes there must be ignored
  localparam logic [ffr_pkg::CfgIndexW-1:0] CfgSpareIdx = 8'd4;
  localparam logic [ffr_pkg::CfgIndexW-1:0] CfgTopIdx   = 8'hFF;

  typedef struct packed {
    logic             ok;
    logic [7:0]       ftype;
    logic [63:0]      payload;
  } frame_result_t;

  // DUT signals, the inputs all known from time zero
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [ffr_pkg::CfgIndexW-1:0] cfg_index_i   = '0;
  logic [7:0]                    cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;    // [7:0] rx_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [71:0]                   m_axis_tdata;          // [7:0] frame_type, [71:8] payload
  logic [0:0]                    m_axis_tuser;          // [0] frame_ok

  // Deframer model state
  ffr_pkg::cfg_t            cfg_model;
  logic [ffr_pkg::PosW-1:0] rx_pos;
  logic [7:0]               frame_store [StoreDepth];
  frame_result_t            pending_frames [$];
  logic [7:0]               byte_q [$];

  // Bench control and statistics
  bit            src_idle_en;
  bit            snk_idle_en;
  int unsigned   hold_req;
  int unsigned   error_count;
  int unsigned   bytes_sent;
  int unsigned   frames_checked;
  int unsigned   frames_good;
  int unsigned   cfg_writes;
  int unsigned   quiet_cycles;
  int unsigned   gap_left;
  int unsigned   stall_left;
  int unsigned   hold_seen;
  frame_result_t want_frame;

  fixed_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Keeps frame content from restarting the frame
  function automatic logic [7:0] avoid_sync(input logic [7:0] b);
    return (b == cfg_model.sync_byte) ? ~b : b;
  endfunction

  // Model: one accepted byte, possibly one finished frame
  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t res;
    int            i;
    if (b == cfg_model.sync_byte) begin
      rx_pos = ffr_pkg::PosW'(1);
    end else if (rx_pos != '0) begin
      if (rx_pos < EndPos) begin
        frame_store[rx_pos - 1'b1] = b;
        rx_pos = rx_pos + 1'b1;
      end else begin
        res.ftype   = frame_store[0];
        res.payload = '0;
        for (i = 1; i < StoreDepth; i++)
          res.payload = (res.payload << 8) | 64'(frame_store[i]);
        res.ok = (b == cfg_model.end_byte) && (res.ftype >= cfg_model.type_low) &&
                 (res.ftype <= cfg_model.type_high);
        pending_frames.push_back(res);
        rx_pos = '0;
      end
    end
  endfunction

  function automatic void apply_reg(input logic [ffr_pkg::CfgIndexW-1:0] idx,
                                    input logic [7:0] val);
    case (idx)
      ffr_pkg::CfgSyncByte: cfg_model.sync_byte = val;
      ffr_pkg::CfgEndByte:  cfg_model.end_byte  = val;
      ffr_pkg::CfgTypeLow:  cfg_model.type_low  = val;
      ffr_pkg::CfgTypeHigh: cfg_model.type_high = val;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // One register write transaction
  task automatic write_reg(input logic [ffr_pkg::CfgIndexW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic load_regs(input logic [7:0] sync_b, input logic [7:0] end_b,
                           input logic [7:0] low_b, input logic [7:0] high_b);
    write_reg(ffr_pkg::CfgSyncByte, sync_b);
    write_reg(ffr_pkg::CfgEndByte, end_b);
    write_reg(ffr_pkg::CfgTypeLow, low_b);
    write_reg(ffr_pkg::CfgTypeHigh, high_b);
  endtask

  // Wait for the sender to empty, the last frame to close and all frames
  // to come back
  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid || rx_pos != '0 ||
           pending_frames.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sync, type, random payload, closing byte
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] fin);
    int j;
    byte_q.push_back(cfg_model.sync_byte);
    byte_q.push_back(ftype);
    for (j = 0; j < PayloadBytes; j++) byte_q.push_back(avoid_sync(rand_byte()));
    byte_q.push_back(fin);
  endtask

  // Mostly well-formed frames, some noise and frames cut short by a sync.
  // Always ends on a frame that completes, so the deframer is left hunting.
  task automatic queue_traffic(input int n_bytes);
    int         pushed;
    int         kind;
    int         len;
    int         j;
    logic [7:0] ftype;
    logic [7:0] fin;
    pushed = 0;
    while (pushed < n_bytes) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if (kind <= 3 && cfg_model.type_low <= cfg_model.type_high)
          ftype = 8'($urandom_range(cfg_model.type_high, cfg_model.type_low));
        else
          ftype = rand_byte();
        fin = ($urandom_range(0, 3) != 0) ? cfg_model.end_byte : avoid_sync(rand_byte());
        queue_frame(avoid_sync(ftype), fin);
        pushed += EndPos + 1;
      end else if (kind == 7) begin
        // line noise, a sync only by chance
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) byte_q.push_back(rand_byte());
        pushed += len;
      end else begin
        // partial frame; the next sync restarts it at any position
        len = $urandom_range(0, EndPos - 1);
        byte_q.push_back(cfg_model.sync_byte);
        for (j = 0; j < len; j++) byte_q.push_back(avoid_sync(rand_byte()));
        byte_q.push_back(cfg_model.sync_byte);
        pushed += len + 2;
      end
    end
    fin = (cfg_model.end_byte == cfg_model.sync_byte) ? ~cfg_model.sync_byte
                                                      : cfg_model.end_byte;
    queue_frame(avoid_sync(rand_byte()), fin);
  endtask

  // Byte driver: feeds s_axis from byte_q with random gaps, predicts on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q.pop_front();
          if (src_idle_en && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random ready bursts, long hold on request, compare
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_seen  = hold_req;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        frames_checked++;
        if (pending_frames.size() == 0) begin
          report_mismatch("unexpected frame", m_axis_tdata[71:8], '0);
        end else begin
          want_frame = pending_frames.pop_front();
          if (want_frame.ok) frames_good++;
          if (m_axis_tuser[0] != want_frame.ok)
            report_mismatch("frame_ok", 64'(m_axis_tuser[0]), 64'(want_frame.ok));
          if (m_axis_tdata[7:0] != want_frame.ftype)
            report_mismatch("frame_type", 64'(m_axis_tdata[7:0]), 64'(want_frame.ftype));
          if (m_axis_tdata[71:8] != want_frame.payload)
            report_mismatch("payload", m_axis_tdata[71:8], want_frame.payload);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (snk_idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns: no transaction for %0d cycles, %0d frames outstanding",
                 $time, quiet_cycles, pending_frames.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Phase sequencing
  initial begin
    cfg_model.sync_byte = ffr_pkg::SyncByteRst;
    cfg_model.end_byte  = ffr_pkg::EndByteRst;
    cfg_model.type_low  = ffr_pkg::TypeLowRst;
    cfg_model.type_high = ffr_pkg::TypeHighRst;
    rx_pos      = '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: noise while hunting, a good frame, a restart at a
    // payload position, then a frame rejected on type and end byte
    byte_q = {8'h00, 8'hFF,
              8'hEF, 8'h52, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hFE,
              8'hEF, 8'h51, 8'h11, 8'h22, 8'h33,
              8'hEF, 8'h54, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00};
    queue_traffic(150);
    wait_drained();

    // Full type window, zero sync, all-ones end
    src_idle_en = 1'b0;
    load_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
    queue_traffic(150);
    wait_drained();

    // Single-value window at the top; long output stall backs up the input
    load_regs(8'hFF, 8'h00, 8'hFF, 8'hFF);
    hold_req++;
    queue_traffic(120);
    wait_drained();

    // End byte equal to sync: frames cannot close on it; spare indexes ignored
    src_idle_en = 1'b1;
    load_regs(8'h5A, 8'h5A, 8'h10, 8'h20);
    write_reg(CfgSpareIdx, 8'h00);
    write_reg(CfgTopIdx, 8'h33);
    queue_traffic(40);
    wait_drained();

    // Empty type window: every frame rejected
    snk_idle_en = 1'b0;
    load_regs(8'hA5, 8'h3C, 8'hC0, 8'h40);
    queue_traffic(120);
    wait_drained();

    // Random settings
    snk_idle_en = 1'b1;
    repeat (2) begin
      load_regs(rand_byte(), rand_byte(), 8'($urandom_range(0, 120)),
                8'($urandom_range(100, 255)));
      queue_traffic(120);
      wait_drained();
    end

    // Back to reset values, no idling at all
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    load_regs(ffr_pkg::SyncByteRst, ffr_pkg::EndByteRst, ffr_pkg::TypeLowRst,
              ffr_pkg::TypeHighRst);
    queue_traffic(150);
    wait_drained();

    $display("Sent %0d bytes over 8 register settings (%0d register writes).",
             bytes_sent, cfg_writes);
    $display("Checked %0d frames: %0d accepted, %0d rejected; %0d mismatches.",
             frames_checked, frames_good, frames_checked - frames_good, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ffr_pkg.sv
rtl/core/ffr_cfg_regs.sv
rtl/core/ffr_assembler.sv
rtl/core/fixed_frame_receiver.sv
bench/tb_fixed_frame_receiver.sv
